@@ rtl/core/srbt_pkg.sv @@
// Shared types, constants and helpers for the sorted range blocklist table.
package srbt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = 64;
  localparam int OUT_IDX_W   = 6;
  localparam int STAT_W      = 2;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t STAT_INSERTED = 2'd0;
  localparam status_t STAT_OVERLAP  = 2'd1;
  localparam status_t STAT_FULL     = 2'd2;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // One input transaction.
  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] start_address;
    logic [ADDR_W-1:0] length;
    logic [ADDR_W-1:0] end_address;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic                 hit;
    logic [OUT_IDX_W-1:0] match_index;
    status_t              status;
    logic                 low_conflict_valid;
    logic [OUT_IDX_W-1:0] low_conflict_index;
    logic                 high_conflict_valid;
    logic [OUT_IDX_W-1:0] high_conflict_index;
  } result_t;

  // Query broadcast to every cell; qend is start + length in 65 bits.
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W:0]   qend;
    logic [ADDR_W-1:0] endb;
  } query_t;

  // Cell sequencing controls.
  typedef struct packed {
    logic compare;
    logic commit;
  } cell_ctrl_t;

  // Handed from cell i to cell i+1.
  typedef struct packed {
    logic              gt;
    logic [ADDR_W-1:0] low;
    logic [ADDR_W-1:0] high;
  } cell_link_t;

  // Registered per-cell compare results.
  typedef struct packed {
    logic lk_hit;
    logic lo_in;
    logic hi_in;
  } cell_flag_t;

  // Lowest set bit, truncated to the output index width.
  function automatic logic [OUT_IDX_W-1:0] first_set(input logic [TABLE_DEPTH-1:0] v);
    logic [OUT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (v[i]) idx = OUT_IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ rtl/core/srbt_cell.sv @@
// One table cell: holds a range, compares it to the query, shifts on insert.
module srbt_cell import srbt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  query_t     query_i,
  input  logic       occ_i,
  input  logic       occ_prev_i,
  input  cell_link_t prev_i,
  output cell_link_t link_o,
  output cell_flag_t flag_o
);

  logic [ADDR_W-1:0] low_q, high_q;
  logic              gt_q;
  cell_flag_t        flag_q;
  cell_flag_t        flag_d;
  logic              gt_d;
  logic              take_nb, load_new;

  always_comb begin
    flag_d.lk_hit = occ_i && (query_i.qend > {1'b0, low_q}) && (query_i.start < high_q);
    flag_d.lo_in  = occ_i && (low_q <= query_i.start) && (query_i.start < high_q);
    flag_d.hi_in  = occ_i && (low_q <= query_i.endb) && (query_i.endb < high_q);
    gt_d          = occ_i && (query_i.start < low_q);
  end

  // upper neighbor moves in; first shifting cell or first free cell takes the new range
  assign take_nb  = prev_i.gt;
  assign load_new = !take_nb && (gt_q || (!occ_i && occ_prev_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= '0;
      gt_q   <= 1'b0;
    end else if (ctrl_i.compare) begin
      flag_q <= flag_d;
      gt_q   <= gt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      if (take_nb) begin
        low_q  <= prev_i.low;
        high_q <= prev_i.high;
      end else if (load_new) begin
        low_q  <= query_i.start;
        high_q <= query_i.endb;
      end
    end
  end

  assign link_o = '{gt: gt_q, low: low_q, high: high_q};
  assign flag_o = flag_q;

endmodule

@@ rtl/core/sorted_range_blocklist_table.sv @@
// Top level of the sorted range blocklist table: cell chain plus sequencer.
//
//  channel  | handshake          | payload   | direction
//  ---------+--------------------+-----------+----------
//  request  | start, busy        | item_i    | in
//  response | done_o (1 cycle)   | result_o  | out
//
// A request is taken at a clock edge with start high and busy low.
// Each transaction runs the parallel compare in all cells in the compare cycle,
// then encodes the lowest matching cell and commits an insert shift in the finish cycle.
// The response follows in the cycle after that, for a single cycle, strobed by done_o.
// busy is high only in the compare cycle, so a new request can overlap the
// response cycle. The receiver cannot stall. Reset empties the table at once.
module sorted_range_blocklist_table import srbt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    done_o,
  output result_t result_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic              accept;
  logic              cmd_q;
  query_t            query_q;
  logic [CNT_W-1:0]  count_q;
  logic              done_q;
  result_t           result_q, result_d;
  cell_ctrl_t        ctrl;
  logic              ins_ok;

  logic [TABLE_DEPTH-1:0] occ;
  logic [TABLE_DEPTH-1:0] lk_vec, lo_vec, hi_vec;
  cell_link_t             links [TABLE_DEPTH];
  cell_flag_t             flags [TABLE_DEPTH];

  // Idle or finishing: the table is consistent for a new compare next cycle.
  assign busy   = (state_q == ST_CMP);
  assign accept = start && !busy;

  always_comb begin
    case (state_q)
      ST_IDLE: state_d = accept ? ST_CMP : ST_IDLE;
      ST_CMP:  state_d = ST_FIN;
      ST_FIN:  state_d = accept ? ST_CMP : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Request capture; query end is formed in 65 bits so it never wraps.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q         <= item_i.command;
      query_q.start <= item_i.start_address;
      query_q.endb  <= item_i.end_address;
      query_q.qend  <= {1'b0, item_i.start_address} + {1'b0, item_i.length};
    end
  end

  // Occupancy thermometer from the entry count.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      occ[i] = (CNT_W'(i) < count_q);
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      lk_vec[i] = flags[i].lk_hit;
      lo_vec[i] = flags[i].lo_in;
      hi_vec[i] = flags[i].hi_in;
    end
  end

  // Result build in the finish cycle. Overlap beats full.
  always_comb begin
    result_d = '0;
    ins_ok   = 1'b0;
    if (cmd_q == CMD_LOOKUP) begin
      result_d.hit         = |lk_vec;
      result_d.match_index = first_set(lk_vec);
    end else if ((|lo_vec) || (|hi_vec)) begin
      result_d.status              = STAT_OVERLAP;
      result_d.low_conflict_valid  = |lo_vec;
      result_d.low_conflict_index  = first_set(lo_vec);
      result_d.high_conflict_valid = |hi_vec;
      result_d.high_conflict_index = first_set(hi_vec);
    end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
      result_d.status = STAT_FULL;
    end else begin
      result_d.status = STAT_INSERTED;
      ins_ok          = 1'b1;
    end
  end

  assign ctrl.compare = (state_q == ST_CMP);
  assign ctrl.commit  = (state_q == ST_FIN) && (cmd_q == CMD_INSERT) && ins_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_FIN);
      if (ctrl.commit) count_q <= count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN) result_q <= result_d;
  end

  // Cell chain: cell 0 has no upper neighbor and always follows a full slot.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    cell_link_t prev;
    logic       occ_prev;
    if (g == 0) begin : g_head
      assign prev     = '0;
      assign occ_prev = 1'b1;
    end else begin : g_body
      assign prev     = links[g-1];
      assign occ_prev = occ[g-1];
    end
    srbt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .query_i    (query_q),
      .occ_i      (occ[g]),
      .occ_prev_i (occ_prev),
      .prev_i     (prev),
      .link_o     (links[g]),
      .flag_o     (flags[g])
    );
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

@@ rtl/core/srbt_checker.sv @@
// Port-level checker for the sorted range blocklist table, bound to the top level.
module srbt_checker import srbt_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input item_t   item_i,
  input logic    done_o,
  input result_t result_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised after accept");

  a_compare_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy) else $error("compare phase longer than one cycle");

  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> ##2 done_o) else $error("response missing three cycles after accept");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("response strobe held two cycles");

  a_lookup_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.hit |-> result_o.status == STAT_INSERTED &&
      !result_o.low_conflict_valid && !result_o.high_conflict_valid)
    else $error("lookup hit carries insert fields");

endmodule

bind sorted_range_blocklist_table srbt_checker u_srbt_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .done_o   (done_o),
  .result_o (result_o)
);

@@ tb/range_table_checker.sv @@
`timescale 1ns / 100ps
// Checker for the range table: keeps a shadow table, predicts each outcome and compares.
module range_table_checker import srbt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    busy_i,
  input  item_t   item_i,
  input  logic    done_i,
  input  result_t result_i,
  output int      errors_o,
  output int      pending_o
);

  logic [ADDR_W-1:0] range_lo_tab [TABLE_DEPTH];
  logic [ADDR_W-1:0] range_hi_tab [TABLE_DEPTH];
  int                n_ranges;
  result_t           expected_outcomes [$];

  // Outcome of one transaction; an accepted insert also updates the shadow table.
  function automatic result_t predict_outcome(input item_t it);
    result_t         r;
    logic [ADDR_W:0] qend;
    logic            lo_in, hi_in;
    int              lo_idx, hi_idx, pos;
    r = '0;
    if (it.command == CMD_LOOKUP) begin
      // query end carries into bit 64, never wraps
      qend = {1'b0, it.start_address} + {1'b0, it.length};
      for (int i = 0; i < n_ranges; i++) begin
        if (!r.hit && qend > {1'b0, range_lo_tab[i]} &&
            it.start_address < range_hi_tab[i]) begin
          r.hit         = 1'b1;
          r.match_index = OUT_IDX_W'(i);
        end
      end
    end else begin
      lo_in  = 1'b0;
      hi_in  = 1'b0;
      lo_idx = 0;
      hi_idx = 0;
      for (int i = 0; i < n_ranges; i++) begin
        if (!lo_in && range_lo_tab[i] <= it.start_address &&
            it.start_address < range_hi_tab[i]) begin
          lo_in  = 1'b1;
          lo_idx = i;
        end
        if (!hi_in && range_lo_tab[i] <= it.end_address &&
            it.end_address < range_hi_tab[i]) begin
          hi_in  = 1'b1;
          hi_idx = i;
        end
      end
      if (lo_in || hi_in) begin
        // overlap wins over full
        r.status              = STAT_OVERLAP;
        r.low_conflict_valid  = lo_in;
        r.low_conflict_index  = lo_in ? OUT_IDX_W'(lo_idx) : '0;
        r.high_conflict_valid = hi_in;
        r.high_conflict_index = hi_in ? OUT_IDX_W'(hi_idx) : '0;
      end else if (n_ranges >= TABLE_DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        pos = n_ranges;
        for (int i = n_ranges - 1; i >= 0; i--) begin
          if (it.start_address < range_lo_tab[i]) pos = i;
        end
        for (int i = n_ranges; i > pos; i--) begin
          range_lo_tab[i] = range_lo_tab[i-1];
          range_hi_tab[i] = range_hi_tab[i-1];
        end
        range_lo_tab[pos] = it.start_address;
        range_hi_tab[pos] = it.end_address;
        n_ranges++;
        r.status = STAT_INSERTED;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors_o++;
  endtask

  task automatic compare_outcome(input result_t got);
    result_t want;
    if (expected_outcomes.size() == 0) begin
      report_mismatch("result with no transaction pending", 64'(got), 64'd0);
    end else begin
      want = expected_outcomes.pop_front();
      if (got.hit != want.hit) report_mismatch("hit", 64'(got.hit), 64'(want.hit));
      if (got.match_index != want.match_index)
        report_mismatch("match_index", 64'(got.match_index), 64'(want.match_index));
      if (got.status != want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.low_conflict_valid != want.low_conflict_valid)
        report_mismatch("low_conflict_valid", 64'(got.low_conflict_valid),
                        64'(want.low_conflict_valid));
      if (got.low_conflict_index != want.low_conflict_index)
        report_mismatch("low_conflict_index", 64'(got.low_conflict_index),
                        64'(want.low_conflict_index));
      if (got.high_conflict_valid != want.high_conflict_valid)
        report_mismatch("high_conflict_valid", 64'(got.high_conflict_valid),
                        64'(want.high_conflict_valid));
      if (got.high_conflict_index != want.high_conflict_index)
        report_mismatch("high_conflict_index", 64'(got.high_conflict_index),
                        64'(want.high_conflict_index));
    end
  endtask

  // Result of an older transaction is checked before the new one is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_ranges = 0;
      expected_outcomes.delete();
      pending_o = 0;
    end else begin
      if (done_i) compare_outcome(result_i);
      if (start_i && !busy_i) expected_outcomes.push_back(predict_outcome(item_i));
      pending_o = expected_outcomes.size();
    end
  end

endmodule

@@ tb/sorted_range_blocklist_table_test.sv @@
`timescale 1ns / 100ps
// Top of the range table testbench: clock, reset, stimulus and verdict.
module sorted_range_blocklist_table_test;
  import srbt_pkg::*;

  localparam int          N_RANDOM  = 1200;
  // Random transaction at which the table is forced full by a burst of inserts.
  localparam int          FILL_AT   = 800;
  // Private window for the fill burst, far from the other address windows.
  localparam logic [63:0] FILL_BASE = 64'h5555_0000_0000_0000;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item;
  logic    done;
  result_t result;
  int      n_errors;
  int      n_pending;

  // Most random addresses fall in this 1 MiB window so ranges collide often.
  logic [63:0] hot_base;
  // Bounds of every insert sent so far; lookups and abutting inserts aim at them.
  logic [63:0] sent_bounds [$];

  sorted_range_blocklist_table dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item),
    .done_o   (done),
    .result_o (result)
  );

  range_table_checker chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .busy_i    (busy),
    .item_i    (item),
    .done_i    (done),
    .result_i  (result),
    .errors_o  (n_errors),
    .pending_o (n_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit: far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("[sorted_range_blocklist_table] ERROR");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic item_t mk_item(input logic cmd, input logic [63:0] a,
                                    input logic [63:0] len, input logic [63:0] b);
    item_t it;
    it.command       = cmd;
    it.start_address = a;
    it.length        = len;
    it.end_address   = b;
    return it;
  endfunction

  // Address mix: mostly the hot window, some near zero, near the top, or anywhere.
  function automatic logic [63:0] pick_addr();
    case ($urandom_range(0, 9))
      0:       return rand64();
      1:       return {44'hFFF_FFFF_FFFF, 20'($urandom)};
      2:       return {44'h0, 20'($urandom)};
      default: return hot_base | 64'($urandom_range(0, 20'hF_FFFF));
    endcase
  endfunction

  function automatic item_t random_lookup();
    logic [63:0] a, len;
    if (sent_bounds.size() > 0 && $urandom_range(0, 1) == 1) begin
      // land just around a stored bound
      a = sent_bounds[$urandom_range(0, sent_bounds.size() - 1)]
          + 64'($urandom_range(0, 512)) - 64'd256;
    end else begin
      a = pick_addr();
    end
    case ($urandom_range(0, 9))
      0, 1:    len = '0;
      2:       len = '1;
      3:       len = rand64();
      4:       len = -a;                    // query end exactly at 2**64
      default: len = 64'($urandom_range(1, 8192));
    endcase
    return mk_item(CMD_LOOKUP, a, len, rand64());
  endfunction

  function automatic item_t random_insert();
    logic [63:0] a, b;
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        // noise: unrelated bounds, often reversed or conflicting
        a = pick_addr();
        b = pick_addr();
      end
      3, 4, 5: begin
        // start right at an earlier bound, so edges get exercised
        a = (sent_bounds.size() > 0) ?
            sent_bounds[$urandom_range(0, sent_bounds.size() - 1)] : pick_addr();
        b = a + 64'($urandom_range(1, 4096));
      end
      default: begin
        a = pick_addr();
        b = a + 64'($urandom_range(1, 8192));
      end
    endcase
    return mk_item(CMD_INSERT, a, rand64(), b);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  // start stays high on return so back-to-back transactions need no extra edge.
  task automatic send_item(input item_t it);
    start <= 1'b1;
    item  <= it;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    @(negedge clk_i);
    if (it.command == CMD_INSERT) begin
      sent_bounds.push_back(it.start_address);
      sent_bounds.push_back(it.end_address);
    end
  endtask

  // Stop sending and wait until every predicted outcome has been checked.
  task automatic wait_drained();
    start <= 1'b0;
    while (n_pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int idle_pct;
    int gap;
    int ins_pct;

    rst_ni   = 1'b0;
    start    = 1'b0;
    item     = '0;
    hot_base = rand64();
    hot_base[19:0] = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed part ----
    // empty table, extreme queries
    send_item(mk_item(CMD_LOOKUP, 64'h0, 64'h0, rand64()));
    send_item(mk_item(CMD_LOOKUP, '1, '1, rand64()));
    // second insert lands below the first and shifts it up
    send_item(mk_item(CMD_INSERT, 64'h1000, rand64(), 64'h2000));
    send_item(mk_item(CMD_INSERT, 64'h100, rand64(), 64'h200));
    // zero length: hits strictly inside, misses at the low bound
    send_item(mk_item(CMD_LOOKUP, 64'h1800, 64'h0, rand64()));
    send_item(mk_item(CMD_LOOKUP, 64'h1000, 64'h0, rand64()));
    send_item(mk_item(CMD_LOOKUP, 64'h0, 64'h101, rand64()));
    // query that exactly fills the gap between the two entries
    send_item(mk_item(CMD_LOOKUP, 64'h200, 64'hE00, rand64()));
    // query end carries past 2**64
    send_item(mk_item(CMD_LOOKUP, 64'h1FFF, '1, rand64()));
    send_item(mk_item(CMD_LOOKUP, '1, '1, rand64()));
    // refusals: low bound inside, high bound inside, both inside
    send_item(mk_item(CMD_INSERT, 64'h1800, rand64(), 64'h3000));
    send_item(mk_item(CMD_INSERT, 64'h50, rand64(), 64'h150));
    send_item(mk_item(CMD_INSERT, 64'h150, rand64(), 64'h1500));
    // enclosing range is accepted; later lookups report the lowest index
    send_item(mk_item(CMD_INSERT, 64'h80, rand64(), 64'h3000));
    send_item(mk_item(CMD_LOOKUP, 64'h1100, 64'h10, rand64()));
    // reversed and empty ranges are stored as given
    send_item(mk_item(CMD_INSERT, 64'h9000, rand64(), 64'h8000));
    send_item(mk_item(CMD_INSERT, 64'hA000, rand64(), 64'hA000));
    send_item(mk_item(CMD_LOOKUP, 64'h8800, 64'h10, rand64()));
    // top of the address space
    send_item(mk_item(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FF00, rand64(), '1));
    send_item(mk_item(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 64'h0, rand64()));
    // bottom of the address space, lands at index 0
    send_item(mk_item(CMD_INSERT, 64'h0, rand64(), 64'h10));
    send_item(mk_item(CMD_LOOKUP, 64'h0, '1, rand64()));
    send_item(mk_item(CMD_INSERT, 64'h2000, rand64(), 64'h2800));

    // sender holds off until the block has answered everything
    wait_drained();

    // ---- random part ----
    // Four idle phases: none, heavy (86%), light (31%), none.
    // Inserts stay rare until the fill burst so lookups see a sparse table first.
    for (int k = 0; k < N_RANDOM; k++) begin
      case ((k * 4) / N_RANDOM)
        1:       idle_pct = 86;
        2:       idle_pct = 31;
        default: idle_pct = 0;
      endcase
      ins_pct = (k < FILL_AT) ? 6 : 30;

      if (k == N_RANDOM / 2) wait_drained();

      gap = 0;
      while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end

      if (k == FILL_AT) begin
        // Disjoint ranges in a private window: the table is full after this,
        // and surplus inserts see the full status.
        for (int j = 0; j < TABLE_DEPTH; j++) begin
          send_item(mk_item(CMD_INSERT, FILL_BASE + 64'(j) * 64'h100, rand64(),
                            FILL_BASE + 64'(j) * 64'h100 + 64'h80));
        end
        // overlap on a full table, then a clean insert into a full table
        send_item(mk_item(CMD_INSERT, FILL_BASE + 64'h10, rand64(), FILL_BASE + 64'h20));
        send_item(mk_item(CMD_INSERT, FILL_BASE - 64'h1000, rand64(), FILL_BASE - 64'h800));
      end

      if ($urandom_range(0, 99) < ins_pct) send_item(random_insert());
      else send_item(random_lookup());
    end

    // ---- drain and verdict ----
    wait_drained();
    repeat (8) @(negedge clk_i);
    if (n_errors == 0 && n_pending == 0) begin
      $display("[sorted_range_blocklist_table] OK");
    end else begin
      $display("[sorted_range_blocklist_table] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/srbt_pkg.sv
rtl/core/srbt_cell.sv
rtl/core/sorted_range_blocklist_table.sv
rtl/core/srbt_checker.sv
tb/range_table_checker.sv
tb/sorted_range_blocklist_table_test.sv
